// ----- design/sma_pkg.sv -----
// Shared types, constants and op decode helpers for the stack machine ALU.
// No dependencies; every other file in design/ refers to this package.
package sma_pkg;

  localparam int DATA_W          = 32;
  localparam int OP_W            = 5;
  localparam int DEPTH_W         = 9;
  localparam int STAT_W          = 2;
  localparam int KIND_W          = 2;
  localparam int STACK_DEPTH_DEF = 256;

  // Opcodes
  localparam logic [OP_W-1:0] OP_PUSH  = 5'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 5'd1;
  localparam logic [OP_W-1:0] OP_SUB   = 5'd2;
  localparam logic [OP_W-1:0] OP_MUL   = 5'd3;
  localparam logic [OP_W-1:0] OP_DIV   = 5'd4;
  localparam logic [OP_W-1:0] OP_MOD   = 5'd5;
  localparam logic [OP_W-1:0] OP_ABS   = 5'd6;
  localparam logic [OP_W-1:0] OP_NEG   = 5'd7;
  localparam logic [OP_W-1:0] OP_MIN   = 5'd8;
  localparam logic [OP_W-1:0] OP_MAX   = 5'd9;
  localparam logic [OP_W-1:0] OP_AND   = 5'd10;
  localparam logic [OP_W-1:0] OP_OR    = 5'd11;
  localparam logic [OP_W-1:0] OP_XOR   = 5'd12;
  localparam logic [OP_W-1:0] OP_NOT   = 5'd13;
  localparam logic [OP_W-1:0] OP_EQ    = 5'd14;
  localparam logic [OP_W-1:0] OP_LT    = 5'd15;
  localparam logic [OP_W-1:0] OP_GT    = 5'd16;
  localparam logic [OP_W-1:0] OP_LE    = 5'd17;
  localparam logic [OP_W-1:0] OP_GE    = 5'd18;
  localparam logic [OP_W-1:0] OP_NE    = 5'd19;
  localparam logic [OP_W-1:0] OP_DOT   = 5'd20;
  localparam logic [OP_W-1:0] OP_CR    = 5'd21;
  localparam logic [OP_W-1:0] OP_BLANK = 5'd22;
  localparam logic [OP_W-1:0] OP_EMIT  = 5'd23;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZDIV  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_OFLOW = 2'd3;

  // Output kinds
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NUM  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd2;

  localparam logic [DATA_W-1:0] CHAR_CR    = 32'd10;
  localparam logic [DATA_W-1:0] CHAR_SPACE = 32'd32;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] literal;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [KIND_W-1:0]        out_kind;
    logic signed [DATA_W-1:0] out_value;
    logic [DEPTH_W-1:0]       depth;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch the accepted item
    logic pop;        // read top of stack, or flag underflow
    logic cap;        // capture popped operand
    logic cap_a;      // capture into a (second pop) instead of b
    logic exec;       // evaluate the ALU
    logic div_start;  // launch the divider
    logic div_take;   // take the sign-corrected divider result
    logic push;       // write the result back
    logic emit;       // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] npops;
    logic       div_go;
    logic       div_done;
    logic       out_free;
  } dp_stat_t;

  // Number of stack pops an op performs
  function automatic logic [1:0] op_pops(input logic [OP_W-1:0] op);
    logic [1:0] n;
    unique case (op) inside
      OP_ABS, OP_NEG, OP_NOT, OP_DOT, OP_EMIT:   n = 2'd1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_MIN, OP_MAX,
      OP_AND, OP_OR, OP_XOR, OP_EQ, OP_LT, OP_GT, OP_LE, OP_GE,
      OP_NE:                                     n = 2'd2;
      default:                                   n = 2'd0;
    endcase
    return n;
  endfunction

  // Whether an op pushes a result (zero-divisor case handled separately)
  function automatic logic op_pushes(input logic [OP_W-1:0] op);
    return op <= OP_NE;
  endfunction

endpackage

// ----- design/sma_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sma_pkg for the data width.
module sma_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sma_pkg::DATA_W-1:0] dividend,
  input  logic [sma_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [sma_pkg::DATA_W-1:0] quot,
  output logic [sma_pkg::DATA_W-1:0] rem
);

  localparam int W     = sma_pkg::DATA_W;
  localparam int CNT_W = $clog2(W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     dsr_r, dsr_nxt;
  logic [W:0]       rem_sh;
  logic [W:0]       diff;

  always_comb begin
    rem_sh   = {rem_r, quo_r[W-1]};
    diff     = rem_sh - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract if it fits
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// ----- design/sma_ctrl.sv -----
// Sequencing state machine for the stack machine ALU.
// Depends on sma_pkg for cmd_t and dp_stat_t.
module sma_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sma_pkg::dp_stat_t stat,
  output sma_pkg::cmd_t     cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_POP  = 7'b0000010,
    S_CAP  = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_PUSH = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] pop_idx_r, pop_idx_nxt;

  always_comb begin
    state_nxt   = state_r;
    pop_idx_nxt = pop_idx_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          pop_idx_nxt = 2'd0;
          state_nxt   = S_POP;
        end
      end
      S_POP: begin
        if (pop_idx_r == stat.npops) begin
          state_nxt = S_EXEC;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_CAP;
        end
      end
      S_CAP: begin
        cmd.cap     = 1'b1;
        cmd.cap_a   = pop_idx_r[0];
        pop_idx_nxt = pop_idx_r + 2'd1;
        state_nxt   = S_POP;
      end
      S_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.div_start = stat.div_go;
        state_nxt     = stat.div_go ? S_DIV : S_PUSH;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pop_idx_r <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      pop_idx_r <= pop_idx_nxt;
    end
  end

endmodule

// ----- design/sma_dpath.sv -----
// Datapath: stack memory, stack pointer, operand registers, ALU, divider
// and output register. Depends on sma_pkg and sma_div.
module sma_dpath #(
  parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sma_pkg::cmd_t      cmd,
  output sma_pkg::dp_stat_t  stat,
  input  sma_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sma_pkg::out_item_t out_data
);

  localparam int W   = sma_pkg::DATA_W;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [W-1:0] mem [STACK_DEPTH];

  logic [sma_pkg::OP_W-1:0]   op_r;
  logic signed [W-1:0]        lit_r, a_r, b_r, res_r, outv_r;
  logic [sma_pkg::KIND_W-1:0] kind_r;
  logic [W-1:0]               rdata_r;
  logic                       uf_r, ovf_r, empty_r;
  logic [SPW-1:0]             sp_r, sp_nxt;
  logic                       out_valid_r, out_valid_nxt;
  sma_pkg::out_item_t         out_r;

  logic                       is_div, b_zero, do_push, full;
  logic                       a_lt_b, b_lt_a;
  logic signed [W-1:0]        alu_res, outv_nxt, opnd;
  logic [sma_pkg::KIND_W-1:0] kind_nxt;
  logic [W-1:0]               ua, ub, quot, rem, q_fix, r_fix;
  logic                       div_done;
  logic [sma_pkg::STAT_W-1:0] status;
  logic [AW-1:0]              rd_addr, wr_addr;

  assign is_div  = (op_r == sma_pkg::OP_DIV) || (op_r == sma_pkg::OP_MOD);
  assign b_zero  = (b_r == '0);
  assign do_push = sma_pkg::op_pushes(op_r) && !(is_div && b_zero);
  assign full    = (sp_r == SPW'(STACK_DEPTH));
  assign a_lt_b  = a_r < b_r;
  assign b_lt_a  = b_r < a_r;
  assign rd_addr = AW'(sp_r - SPW'(1));
  assign wr_addr = AW'(sp_r);
  assign opnd    = empty_r ? '0 : rdata_r;

  assign stat.npops    = sma_pkg::op_pops(op_r);
  assign stat.div_go   = is_div && !b_zero;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_ready;

  // Magnitudes for the divider; the most negative value maps to 2^31
  assign ua    = a_r[W-1] ? W'(-a_r) : a_r;
  assign ub    = b_r[W-1] ? W'(-b_r) : b_r;
  assign q_fix = (a_r[W-1] ^ b_r[W-1]) ? (W'(0) - quot) : quot;
  assign r_fix = a_r[W-1] ? (W'(0) - rem) : rem;

  sma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (ua),
    .divisor  (ub),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  always_comb begin
    unique case (op_r)
      sma_pkg::OP_PUSH: alu_res = lit_r;
      sma_pkg::OP_ADD:  alu_res = a_r + b_r;
      sma_pkg::OP_SUB:  alu_res = a_r - b_r;
      sma_pkg::OP_MUL:  alu_res = a_r * b_r;
      sma_pkg::OP_ABS:  alu_res = b_r[W-1] ? -b_r : b_r;
      sma_pkg::OP_NEG:  alu_res = -b_r;
      sma_pkg::OP_MIN:  alu_res = a_lt_b ? a_r : b_r;
      sma_pkg::OP_MAX:  alu_res = b_lt_a ? a_r : b_r;
      sma_pkg::OP_AND:  alu_res = a_r & b_r;
      sma_pkg::OP_OR:   alu_res = a_r | b_r;
      sma_pkg::OP_XOR:  alu_res = a_r ^ b_r;
      sma_pkg::OP_NOT:  alu_res = ~b_r;
      sma_pkg::OP_EQ:   alu_res = {W{a_r == b_r}};
      sma_pkg::OP_LT:   alu_res = {W{a_lt_b}};
      sma_pkg::OP_GT:   alu_res = {W{b_lt_a}};
      sma_pkg::OP_LE:   alu_res = {W{!b_lt_a}};
      sma_pkg::OP_GE:   alu_res = {W{!a_lt_b}};
      sma_pkg::OP_NE:   alu_res = {W{a_r != b_r}};
      default:          alu_res = '0;
    endcase
  end

  always_comb begin
    unique case (op_r)
      sma_pkg::OP_DOT: begin
        outv_nxt = b_r;
        kind_nxt = sma_pkg::KIND_NUM;
      end
      sma_pkg::OP_EMIT: begin
        outv_nxt = W'(b_r[7:0]);
        kind_nxt = sma_pkg::KIND_CHAR;
      end
      sma_pkg::OP_CR: begin
        outv_nxt = sma_pkg::CHAR_CR;
        kind_nxt = sma_pkg::KIND_CHAR;
      end
      sma_pkg::OP_BLANK: begin
        outv_nxt = sma_pkg::CHAR_SPACE;
        kind_nxt = sma_pkg::KIND_CHAR;
      end
      default: begin
        outv_nxt = '0;
        kind_nxt = sma_pkg::KIND_NONE;
      end
    endcase
  end

  // Underflow wins over overflow, overflow over a zero divisor
  always_comb begin
    if (uf_r)
      status = sma_pkg::ST_UFLOW;
    else if (ovf_r)
      status = sma_pkg::ST_OFLOW;
    else if (is_div && b_zero)
      status = sma_pkg::ST_ZDIV;
    else
      status = sma_pkg::ST_OK;
  end

  always_comb begin
    sp_nxt = sp_r;
    if (cmd.pop && (sp_r != '0))
      sp_nxt = sp_r - SPW'(1);
    else if (cmd.push && do_push && !full)
      sp_nxt = sp_r + SPW'(1);
    out_valid_nxt = out_valid_r;
    if (cmd.emit)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && do_push && !full)
      mem[wr_addr] <= res_r;
    if (cmd.pop)
      rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.op;
      lit_r <= in_data.literal;
      uf_r  <= 1'b0;
      ovf_r <= 1'b0;
    end
    if (cmd.pop) begin
      empty_r <= (sp_r == '0);
      if (sp_r == '0)
        uf_r <= 1'b1;
    end
    if (cmd.cap) begin
      if (cmd.cap_a)
        a_r <= opnd;
      else
        b_r <= opnd;
    end
    if (cmd.exec) begin
      res_r  <= alu_res;
      outv_r <= outv_nxt;
      kind_r <= kind_nxt;
    end
    if (cmd.div_take)
      res_r <= (op_r == sma_pkg::OP_DIV) ? q_fix : r_fix;
    if (cmd.push && do_push && full)
      ovf_r <= 1'b1;
    if (cmd.emit) begin
      out_r.status    <= status;
      out_r.out_kind  <= kind_r;
      out_r.out_value <= outv_r;
      out_r.depth     <= sma_pkg::DEPTH_W'(sp_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- design/stack_machine_alu.sv -----
// Top level of the Forth data-stack ALU: controller plus datapath.
// Depends on sma_pkg, sma_ctrl, sma_dpath (which holds sma_div).
//
// One item (opcode plus literal) goes in, exactly one result item comes out.
// The block works on one item at a time: in_ready is high only while the
// controller is idle. A push or a character word pops nothing, unary words
// and print/emit pop one operand and binary words pop two. The stack sits
// in a single-port memory with registered read, so each pop passes through
// a read state and a capture state. Div and mod with a nonzero divisor
// also wait in a divide state on the restoring divider, which retires one
// quotient bit per cycle. Results wait in an output register; once the result
// is loaded the controller goes idle and takes the next item even while that
// result is still waiting for out_ready. Status reports underflow (a pop from
// an empty stack reads 0), overflow (a push onto a full stack is dropped) and
// a zero divisor (both operands consumed, nothing pushed). depth is the low 9
// bits of the stack pointer after the word. Stack entries have no reset.
module stack_machine_alu #(
  parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sma_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sma_pkg::out_item_t out_data
);

  sma_pkg::cmd_t     cmd;
  sma_pkg::dp_stat_t stat;

  // Sequence each item: pop operands, evaluate, divide if needed, push, report
  sma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the stack, operands, ALU, divider and output register
  sma_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An accepted item blocks further input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // The divider finishes only while an item is being worked on
  a_div_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> !in_ready)
    else $error("divider finished with the controller idle");

  // A word that emits nothing reports a zero value
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.out_kind == sma_pkg::KIND_NONE)) |->
      (out_data.out_value == '0))
    else $error("nonzero value with nothing emitted");

  // Only push can overflow, and push emits nothing
  a_oflow_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == sma_pkg::ST_OFLOW)) |->
      (out_data.out_kind == sma_pkg::KIND_NONE))
    else $error("overflow reported on an emitting word");

endmodule
